// File: hdl/scalar_kalman_filter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scalar Kalman filter
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skf: same-cycle check failed");
// next-cycle implication
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skf: next-cycle check failed");
`else
`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants for the scalar Kalman filter and its serial units.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // gain is unsigned Q0.16 with one extra bit so that one itself fits
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_W      = GAIN_BITS + 1;
    localparam int STEP_CNT_W  = $clog2(GAIN_BITS + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

    // reset value of the variance and noise registers, integer part
    localparam int NOISE_RESET_INT = 200;

    localparam int CFG_ADDR_W = 4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_EST = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_VAR = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_PROC_NSE = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_NSE = CFG_ADDR_W'(3);

endpackage

`default_nettype wire

// File: hdl/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter - one-dimensional Kalman filter, Q16.16 data, Q0.16 gain
// A new measurement is taken only after the last one's result is committed; the
// 17-step serial gain divider and the 17-step serial multipliers that follow it
// set the time per item.
// Reset: synchronous, active low; registers to defaults, estimate 0, variance 200.0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_macros.svh"

module scalar_kalman_filter #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [skf_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [DATA_WIDTH-1:0]           i_cfg_wdata,

    // measurement channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [DATA_WIDTH-1:0]    i_measurement,
    input  wire logic                            i_restart,

    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [DATA_WIDTH-1:0]         o_estimate,
    output logic [skf_pkg::GAIN_W-1:0]           o_gain,
    output logic [DATA_WIDTH-1:0]                o_variance,
    output logic                                 o_saturated
);
    import skf_pkg::*;

    // 200.0 in the chosen fixed-point format, cut to the data width
    localparam logic [63:0]           NOISE_RST_FULL = 64'(NOISE_RESET_INT) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] NOISE_RST      = NOISE_RST_FULL[DATA_WIDTH-1:0];

    // Sequencer: IDLE takes a transfer, PRED forms p+q and z-x, DIV waits for
    // the gain, MUL waits for the correction product, OUT commits state and result.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [DATA_WIDTH-1:0] r_init_est;
    logic [DATA_WIDTH-1:0] r_init_var;
    logic [DATA_WIDTH-1:0] r_proc_nse;
    logic [DATA_WIDTH-1:0] r_meas_nse;

    // filter state
    logic [DATA_WIDTH-1:0] r_est;
    logic [DATA_WIDTH-1:0] r_var;

    // per-item working registers
    logic [DATA_WIDTH-1:0] r_z;
    logic [DATA_WIDTH-1:0] r_pp;
    logic                  r_sat;
    logic [DATA_WIDTH:0]   r_mag;
    logic                  r_neg;
    logic [GAIN_W-1:0]     r_k;
    logic                  r_div_go;
    logic                  r_mul_go;

    // result register
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_est;
    logic [GAIN_W-1:0]     r_out_gain;
    logic [DATA_WIDTH-1:0] r_out_var;
    logic                  r_out_sat;

    // datapath
    logic [DATA_WIDTH:0]   pp_sum;
    logic [DATA_WIDTH:0]   diff;
    logic [GAIN_W-1:0]     k_inv;
    logic [DATA_WIDTH+1:0] est_sum;

    logic                  div_done;
    logic [GAIN_W-1:0]     div_gain;
    logic                  mul_est_done;
    logic [DATA_WIDTH:0]   mul_est_prod;
    logic                  mul_var_done;
    logic [DATA_WIDTH:0]   mul_var_prod;

    always_comb begin
        // predicted variance, one carry bit to catch overflow
        pp_sum  = {1'b0, r_var} + {1'b0, r_proc_nse};
        // innovation z - x, sign-extended by one bit so it cannot wrap
        diff    = {r_z[DATA_WIDTH-1], r_z} - {r_est[DATA_WIDTH-1], r_est};
        k_inv   = GAIN_ONE - r_k;
        // correction magnitude never exceeds |z - x|, so x +/- corr stays in range
        est_sum = r_neg ? ({r_est[DATA_WIDTH-1], r_est[DATA_WIDTH-1], r_est}
                           - {1'b0, mul_est_prod})
                        : ({r_est[DATA_WIDTH-1], r_est[DATA_WIDTH-1], r_est}
                           + {1'b0, mul_est_prod});
    end

    // configuration writes; indices past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_est <= '0;
            r_init_var <= NOISE_RST;
            r_proc_nse <= NOISE_RST;
            r_meas_nse <= NOISE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_INIT_EST: r_init_est <= i_cfg_wdata;
                CFG_INIT_VAR: r_init_var <= i_cfg_wdata;
                CFG_PROC_NSE: r_proc_nse <= i_cfg_wdata;
                CFG_MEAS_NSE: r_meas_nse <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, filter state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_est       <= '0;
            r_var       <= NOISE_RST;
            r_div_go    <= 1'b0;
            r_mul_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_mul_go <= 1'b0;
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_z <= i_measurement;
                        // restart reloads the state before this step uses it
                        if (i_restart) begin
                            r_est <= r_init_est;
                            r_var <= r_init_var;
                        end
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    if (pp_sum[DATA_WIDTH]) begin
                        r_pp  <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_pp  <= pp_sum[DATA_WIDTH-1:0];
                        r_sat <= 1'b0;
                    end
                    r_neg    <= diff[DATA_WIDTH];
                    r_mag    <= diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_k      <= div_gain;
                        r_mul_go <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_est_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold here while an earlier result is still waiting
                    if (!r_out_valid || i_ready) begin
                        r_est       <= est_sum[DATA_WIDTH-1:0];
                        r_var       <= mul_var_prod[DATA_WIDTH-1:0];
                        r_out_est   <= est_sum[DATA_WIDTH-1:0];
                        r_out_gain  <= r_k;
                        r_out_var   <= mul_var_prod[DATA_WIDTH-1:0];
                        r_out_sat   <= r_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // gain k = p / (p + r), forced to zero when p + r is zero
    skf_div_serial #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_div_go),
        .i_pred_var   (r_pp),
        .i_meas_noise (r_meas_nse),
        .o_done       (div_done),
        .o_gain       (div_gain)
    );

    // correction k * |z - x|
    skf_mul_serial #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul_est (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_go),
        .i_mcand  (r_mag),
        .i_mplier (r_k),
        .o_done   (mul_est_done),
        .o_prod   (mul_est_prod)
    );

    // updated variance (1 - k) * p, run alongside the correction
    skf_mul_serial #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul_var (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_go),
        .i_mcand  ({1'b0, r_pp}),
        .i_mplier (k_inv),
        .o_done   (mul_var_done),
        .o_prod   (mul_var_prod)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_estimate  = r_out_est;
    assign o_gain      = r_out_gain;
    assign o_variance  = r_out_var;
    assign o_saturated = r_out_sat;

    `SKF_ASSERT_IMP(a_gain_cap, i_clk, i_rst_n, r_out_valid, r_out_gain <= GAIN_ONE)
    `SKF_ASSERT_IMP(a_div_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `SKF_ASSERT_IMP(a_mul_lockstep, i_clk, i_rst_n, mul_est_done, mul_var_done)
    `SKF_ASSERT_NXT(a_take_to_pred, i_clk, i_rst_n, i_valid && o_ready, r_state == S_PRED)

endmodule

`default_nettype wire

// File: hdl/skf_div_serial.sv
// ----------------------------------------------------------------------------
// skf_div_serial
// Restoring divider, one gain bit per cycle: k = floor(p * 2^16 / (p + r)).
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div_serial #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [DATA_WIDTH-1:0]        i_pred_var,
    input  wire logic [DATA_WIDTH-1:0]        i_meas_noise,
    output logic                              o_done,
    output logic [skf_pkg::GAIN_W-1:0]        o_gain
);
    import skf_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [STEP_CNT_W-1:0]   r_cnt;
    logic [DATA_WIDTH+1:0]   r_rem;
    logic [DATA_WIDTH:0]     r_den;
    logic                    r_den_zero;
    logic [GAIN_W-1:0]       r_quot;

    logic [DATA_WIDTH+2:0]   sub;
    logic                    ge;
    logic                    qbit;
    logic [DATA_WIDTH+1:0]   rem_keep;

    always_comb begin
        sub      = {1'b0, r_rem} - {2'b00, r_den};
        ge       = !sub[DATA_WIDTH+2];
        qbit     = ge && !r_den_zero;
        rem_keep = ge ? sub[DATA_WIDTH+1:0] : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_cnt      <= STEP_CNT_W'(GAIN_BITS);
                r_rem      <= {2'b00, i_pred_var};
                r_den      <= {1'b0, i_pred_var} + {1'b0, i_meas_noise};
                r_den_zero <= (i_pred_var == '0) && (i_meas_noise == '0);
                r_quot     <= '0;
            end else if (r_busy) begin
                // remainder stays below the divisor, so doubling fits
                r_rem  <= {rem_keep[DATA_WIDTH:0], 1'b0};
                r_quot <= {r_quot[GAIN_BITS-1:0], qbit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_quot;

endmodule

`default_nettype wire

// File: hdl/skf_mul_serial.sv
// ----------------------------------------------------------------------------
// skf_mul_serial
// Shift-add multiplier, one multiplier bit per cycle: floor(a * m / 2^16).
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul_serial #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [DATA_WIDTH:0]          i_mcand,
    input  wire logic [skf_pkg::GAIN_W-1:0]   i_mplier,
    output logic                              o_done,
    output logic [DATA_WIDTH:0]               o_prod
);
    import skf_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [STEP_CNT_W-1:0]   r_cnt;
    logic [DATA_WIDTH:0]     r_mcand;
    logic [GAIN_W-1:0]       r_mpl;
    logic [DATA_WIDTH+1:0]   r_acc;

    logic [DATA_WIDTH+1:0]   sum;

    assign sum = r_acc + (r_mpl[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= STEP_CNT_W'(GAIN_BITS);
                r_mcand <= i_mcand;
                r_mpl   <= i_mplier;
                r_acc   <= '0;
            end else if (r_busy) begin
                r_mpl <= {1'b0, r_mpl[GAIN_W-1:1]};
                if (r_cnt == '0) begin
                    // top bit weighs exactly one: no shift
                    r_acc  <= sum;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    // bits shifted out are final product bits below the point
                    r_acc <= {1'b0, sum[DATA_WIDTH+1:1]};
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[DATA_WIDTH:0];

endmodule

`default_nettype wire

// File: tb/scalar_kalman_filter_test.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_test - self-checking bench for the scalar Kalman filter
// Measurements go in through a bursty valid/ready driver and results come out
// through a receiver that stalls on its own pattern. Each transfer is run
// through a cycle-free model of the filter, and every result is checked field
// by field against the oldest prediction. Register settings change between
// batches and include the corner cases: variance clipping, zero denominator,
// zero measurement noise and the extremes of the estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;

    // indexes the block has no register for; writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = CFG_ADDR_W'(15);

    localparam logic [DW-1:0] VAL_ZERO = '0;
    localparam logic [DW-1:0] VAL_ONES = '1;
    localparam logic [DW-1:0] EST_MAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] EST_MIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] NOISE_RESET = DW'(NOISE_RESET_INT) << FRAC_BITS_DEF;

    // cycles with no transfer on either channel before the run is abandoned;
    // covers the long receiver hold-off, sender gaps and phase changes
    localparam int IDLE_LIMIT = 3000;
    // latency of the block, plus margin, for the quiet wait at the end
    localparam int TAIL_CYCLES = 80;
    localparam int HOLD_CYCLES = 500;
    localparam int RANDOM_BATCHES = 6;
    localparam int BATCH_ITEMS = 100;

    typedef struct packed {
        logic signed [DW-1:0] z;
        logic                 restart;
    } t_reading;

    typedef struct packed {
        logic signed [DW-1:0] estimate;
        logic [GAIN_W-1:0]    gain;
        logic [DW-1:0]        variance;
        logic                 saturated;
    } t_filter_out;

    // ------------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [DW-1:0]          i_cfg_wdata = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic signed [DW-1:0]   i_measurement = '0;
    logic                   i_restart = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic signed [DW-1:0]   o_estimate;
    logic [GAIN_W-1:0]      o_gain;
    logic [DW-1:0]          o_variance;
    logic                   o_saturated;

    scalar_kalman_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_measurement (i_measurement),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_estimate    (o_estimate),
        .o_gain        (o_gain),
        .o_variance    (o_variance),
        .o_saturated   (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter model: register copies and state, reset values as in the block
    // ------------------------------------------------------------------------
    logic [DW-1:0] init_est   = '0;
    logic [DW-1:0] init_var   = NOISE_RESET;
    logic [DW-1:0] proc_noise = NOISE_RESET;
    logic [DW-1:0] meas_noise = NOISE_RESET;
    logic [DW-1:0] est_state  = '0;
    logic [DW-1:0] var_state  = NOISE_RESET;

    t_reading    pending_q[$];      // readings not yet offered
    t_filter_out predicted_q[$];    // results owed by the block
    int          items_queued = 0;
    int          items_accepted = 0;
    int          results_seen = 0;
    int          error_count = 0;

    // One filter step: optional reload, predict with clipping, gain, update.
    // Widths are kept in 64 bits so no intermediate product can wrap.
    function automatic t_filter_out kalman_step(input t_reading rd);
        logic [63:0] p_pred;
        logic [63:0] denom;
        logic [63:0] k;
        logic [63:0] mag;
        logic [63:0] corr;
        longint      x;
        longint      diff;
        longint      x_new;
        t_filter_out res;
        if (rd.restart) begin
            est_state = init_est;
            var_state = init_var;
        end
        res.saturated = 1'b0;
        p_pred = 64'(var_state) + 64'(proc_noise);
        if (p_pred > 64'(VAL_ONES)) begin
            p_pred = 64'(VAL_ONES);
            res.saturated = 1'b1;
        end
        denom = p_pred + 64'(meas_noise);
        // zero denominator forces a zero gain
        k = (denom == 64'd0) ? 64'd0 : (p_pred << GAIN_BITS) / denom;
        if (k > 64'(GAIN_ONE))
            k = 64'(GAIN_ONE);
        x = longint'($signed(est_state));
        diff = longint'($signed(rd.z)) - x;
        // correction truncates toward zero, so it is applied to the magnitude
        if (diff < 0) begin
            mag = 64'(-diff);
            corr = (mag * k) >> GAIN_BITS;
            x_new = x - longint'(corr);
        end else begin
            mag = 64'(diff);
            corr = (mag * k) >> GAIN_BITS;
            x_new = x + longint'(corr);
        end
        est_state = x_new[DW-1:0];
        var_state = DW'((p_pred * (64'(GAIN_ONE) - k)) >> GAIN_BITS);
        res.estimate = est_state;
        res.gain = k[GAIN_W-1:0];
        res.variance = var_state;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of readings with random gaps; valid holds until transfer
    // ------------------------------------------------------------------------
    t_reading offered;
    int       burst_left = 1;
    int       gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predicted_q.push_back(kalman_step(offered));
                items_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    offered = pending_q.pop_front();
                    i_measurement <= offered.z;
                    i_restart <= offered.restart;
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // a third of bursts run straight into the next one
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: checks each result transfer, stalls in randomly drawn modes,
    // and once holds off long enough to back up the input
    int  rx_cycle = 0;
    int  rx_mode = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_filter_out exp_res;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (predicted_q.size() == 0) begin
                    $error("result transfer with nothing outstanding: estimate %0d", o_estimate);
                    error_count++;
                end else begin
                    exp_res = predicted_q.pop_front();
                    if (o_estimate !== exp_res.estimate) begin
                        $error("estimate: expected %0d, got %0d", exp_res.estimate, o_estimate);
                        error_count++;
                    end
                    if (o_gain !== exp_res.gain) begin
                        $error("gain: expected %0d, got %0d", exp_res.gain, o_gain);
                        error_count++;
                    end
                    if (o_variance !== exp_res.variance) begin
                        $error("variance: expected %0d, got %0d", exp_res.variance, o_variance);
                        error_count++;
                    end
                    if (o_saturated !== exp_res.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               exp_res.saturated, o_saturated);
                        error_count++;
                    end
                end
            end

            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);

            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 150 && i_valid) begin
                // sender is still offering: starve the output so the block fills
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (rx_cycle % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // write one register; the enable is left high for back-to-back writes
    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            CFG_INIT_EST: init_est = data;
            CFG_INIT_VAR: init_var = data;
            CFG_PROC_NSE: proc_noise = data;
            CFG_MEAS_NSE: meas_noise = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [DW-1:0] est0, input logic [DW-1:0] var0,
                                 input logic [DW-1:0] q, input logic [DW-1:0] r,
                                 input bit stray);
        reg_write(CFG_INIT_EST, est0);
        reg_write(CFG_INIT_VAR, var0);
        reg_write(CFG_PROC_NSE, q);
        reg_write(CFG_MEAS_NSE, r);
        if (stray) begin
            reg_write(CFG_SPARE_LO, $urandom);
            reg_write(CFG_SPARE_HI, $urandom);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_reading(input logic [DW-1:0] z, input logic restart);
        t_reading rd;
        rd.z = z;
        rd.restart = restart;
        pending_q.push_back(rd);
        items_queued++;
    endtask

    // wait until every reading has transferred and every result has come back
    task automatic drain();
        while (items_accepted != items_queued || predicted_q.size() != 0)
            @(posedge i_clk);
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    // noise and variance values: zero, all ones, small and mid-sized mostly
    function automatic logic [DW-1:0] rand_noise();
        case ($urandom_range(0, 7))
            0: return VAL_ZERO;
            1: return VAL_ONES;
            2, 3: return DW'($urandom_range(1, 1 << 20));
            4, 5: return DW'($urandom_range(1 << 16, 1 << 26));
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_measurement();
        int unsigned off;
        off = $urandom_range(0, 1 << 22);
        case ($urandom_range(0, 5))
            0, 1: return DW'($urandom);
            2, 3: return DW'(off) - DW'(1 << 21);
            4: return EST_MAX - DW'(off);
            default: return EST_MIN + DW'(off);
        endcase
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset values: first step runs without a restart, then extremes
        add_reading(VAL_ZERO, 1'b0);
        add_reading(EST_MAX, 1'b0);
        add_reading(EST_MIN, 1'b0);
        add_reading(EST_MIN, 1'b1);
        add_reading(VAL_ZERO, 1'b0);
        add_reading(EST_MAX, 1'b1);
        drain();

        // everything at full scale: variance prediction clips every step;
        // writes to spare indexes must leave the registers alone
        load_settings(EST_MIN, VAL_ONES, VAL_ONES, VAL_ONES, 1'b1);
        add_reading(EST_MAX, 1'b1);
        add_reading(EST_MAX, 1'b0);
        add_reading(EST_MIN, 1'b0);
        add_reading(VAL_ZERO, 1'b0);
        drain();

        // all noise and variance zero: zero denominator, gain forced to zero
        load_settings(EST_MAX, VAL_ZERO, VAL_ZERO, VAL_ZERO, 1'b0);
        add_reading(EST_MIN, 1'b1);
        add_reading(VAL_ZERO, 1'b0);
        drain();

        // zero measurement noise with nonzero predicted variance: gain of exactly one
        load_settings(VAL_ZERO, VAL_ZERO, DW'(1) << FRAC_BITS_DEF, VAL_ZERO, 1'b0);
        add_reading(DW'(12345), 1'b1);
        add_reading(EST_MIN, 1'b0);
        add_reading(EST_MAX, 1'b0);
        drain();

        // zero variance against full measurement noise: gain zero, p + r nonzero
        load_settings(EST_MIN, VAL_ZERO, VAL_ZERO, VAL_ONES, 1'b0);
        add_reading(EST_MAX, 1'b1);
        add_reading(EST_MIN, 1'b0);
        drain();

        // random batches, each opening with a restart to pick up the new values
        for (int b = 0; b < RANDOM_BATCHES; b++) begin
            load_settings(($urandom_range(0, 1) == 0) ? rand_measurement() : DW'($urandom),
                          rand_noise(), rand_noise(), rand_noise(),
                          $urandom_range(0, 2) == 0);
            add_reading(rand_measurement(), 1'b1);
            for (int n = 1; n < BATCH_ITEMS; n++)
                add_reading(rand_measurement(), $urandom_range(0, 11) == 0);
            drain();
        end

        // quiet tail: anything that turns up now is a stray result
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && predicted_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
